@@ rtl/kms_pkg.sv @@
// kms_pkg: shared constants, types and functions of the k-mer minimizer sketch core.
// No dependencies.
package kms_pkg;
  localparam int MAX_WINDOW    = 16;
  localparam int MAX_KMER      = 15;
  localparam int POSITION_BITS = 24;
  localparam int HASH_BITS     = 2 * MAX_KMER;
  localparam int SLOT_BITS     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_BITS      = $clog2(MAX_WINDOW + 1);
  localparam int SEQ_BITS      = 16;
  localparam logic [HASH_BITS:0] SENTINEL = '1;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KMER_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_SIZE = 8'd1;

  typedef logic [HASH_BITS-1:0] hash_t;
  typedef logic [POSITION_BITS-1:0] pos_t;

  // one result transaction
  typedef struct packed {
    hash_t             hash;
    pos_t              pos;
    logic              strand;
    logic [SEQ_BITS-1:0] seq;
    logic              last;
  } result_t;

  // base letter to 2-bit code, A0 C1 G2 T3 from ASCII bits 2:1
  function automatic logic [1:0] base_code(input logic [7:0] b);
    logic [1:0] c;
    case (b[2:1])
      2'd0: c = 2'd0;
      2'd1: c = 2'd1;
      2'd2: c = 2'd3;
      2'd3: c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction
endpackage

@@ rtl/kmer_minimizer_sketch_core.sv @@
// kmer_minimizer_sketch_core: top level, sequencer, window ring and minimum scan.
// Depends on kms_pkg and kms_hash_unit.
//
//  channel  direction  handshake            payload
//  input    in         in_valid/in_stall    forward_base inverted_base sequence_start sequence_index
//  output   out        out_valid/out_stall  minimizer_hash kmer_position strand source_sequence last_of_run
//  config   in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// An item that completes a k-mer is accepted, hashed for both strands (start, seven
// mix steps, done), written to the ring, then scanned for the minimum over up to w slots;
// with a full window, report steps over the w slots and a flush step follow. Other items
// only update the codes and count. With the shared hash unit and the single compare slot in the scan,
// no new item is accepted before the sequencer is idle again. Each report cycle waits while out_stall holds
// a pending result in the output register. Reset (rst, synchronous) clears all control state and registers to 15/10.
module kmer_minimizer_sketch_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  forward_base,
  input  logic [7:0]  inverted_base,
  input  logic        sequence_start,
  input  logic [15:0] sequence_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [29:0] minimizer_hash,
  output logic [23:0] kmer_position,
  output logic        strand,
  output logic [15:0] source_sequence,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0, S_HF = 3'd1, S_HR = 3'd2, S_WR = 3'd3,
                         S_MIN = 3'd4, S_REP = 3'd5, S_LAST = 3'd6;
  localparam int SB = kms_pkg::SLOT_BITS;
  localparam int WB = kms_pkg::WIN_BITS;
  localparam int HB = kms_pkg::HASH_BITS;
  localparam kms_pkg::pos_t COUNT_MAX = '1;

  logic [2:0] state;
  logic [3:0] kmer_length;
  logic [4:0] window_size;
  kms_pkg::hash_t fcode, rcode, fhash;
  kms_pkg::pos_t  base_counter;
  logic [kms_pkg::MAX_WINDOW-1:0] reported;
  logic [HB:0] window_minimum;
  logic [SB-1:0] ring_slot;
  logic [15:0] cur_seq;
  logic [WB-1:0] scan_i, scan_n;
  logic [SB-1:0] scan_s;
  logic found;
  logic [SB-1:0] last_s;

  kms_pkg::hash_t fring [kms_pkg::MAX_WINDOW];
  kms_pkg::hash_t rring [kms_pkg::MAX_WINDOW];
  kms_pkg::pos_t  pring [kms_pkg::MAX_WINDOW];

  // effective k and w
  logic [3:0] k_eff;
  logic [WB-1:0] w_eff;
  kms_pkg::hash_t mask;
  always_comb begin
    k_eff = (kmer_length == 4'd0) ? 4'd1 : kmer_length;
    if (32'(k_eff) > kms_pkg::MAX_KMER) k_eff = 4'(kms_pkg::MAX_KMER);
    w_eff = (window_size == 5'd0) ? WB'(1) : WB'(window_size);
    if (32'(window_size) > kms_pkg::MAX_WINDOW) w_eff = WB'(kms_pkg::MAX_WINDOW);
    mask = HB'(({1'b0, {HB{1'b1}}} >> (HB - 2 * 32'(k_eff))));
  end

  // hash unit shared by both strands
  logic hstart, hdone;
  kms_pkg::hash_t hin, hout;
  assign hin = (state == S_HF) ? fcode : rcode;
  kms_hash_unit u_hash (.clk, .rst, .start(hstart), .din(hin), .mask, .done(hdone),
                        .dout(hout));

  // input decode
  logic accept;
  kms_pkg::hash_t fcode_in, rcode_in;
  kms_pkg::pos_t cnt_in;
  assign in_stall  = (state != S_IDLE) || cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && !in_stall;
  always_comb begin
    kms_pkg::hash_t f0, r0;
    kms_pkg::pos_t c0;
    f0 = sequence_start ? '0 : fcode;
    r0 = sequence_start ? '0 : rcode;
    c0 = sequence_start ? '0 : base_counter;
    fcode_in = HB'({f0, kms_pkg::base_code(forward_base)}) & mask;
    rcode_in = HB'({r0, kms_pkg::base_code(inverted_base)}) & mask;
    cnt_in   = c0;
  end

  // scan slot value and slot position
  logic [HB:0] slot_min;
  logic sym;
  assign sym = fring[scan_s] == rring[scan_s];
  assign slot_min = sym ? kms_pkg::SENTINEL :
                    {1'b0, (fring[scan_s] < rring[scan_s]) ? fring[scan_s] : rring[scan_s]};
  logic [SB:0] wrap_sum;
  assign wrap_sum = (SB+1)'(ring_slot) + (SB+1)'(scan_i);

  kms_pkg::pos_t kmers;
  assign kmers = base_counter - kms_pkg::pos_t'(k_eff) + 1'b1;

  logic hit;
  assign hit = !sym && !reported[scan_s] && (slot_min == window_minimum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kmer_length <= 4'd15;
      window_size <= 5'd10;
      fcode <= '0; rcode <= '0; base_counter <= '0;
      reported <= '0; window_minimum <= kms_pkg::SENTINEL;
      ring_slot <= '0; cur_seq <= '0;
      out_valid <= 1'b0; hstart <= 1'b0; found <= 1'b0;
      scan_i <= '0; scan_n <= '0;
    end else begin
      hstart <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == kms_pkg::REG_KMER_LENGTH) kmer_length <= cfg_data[3:0];
            if (cfg_index == kms_pkg::REG_WINDOW_SIZE) window_size <= cfg_data[4:0];
            if (cfg_index <= kms_pkg::REG_WINDOW_SIZE) begin
              fcode <= '0; rcode <= '0; base_counter <= '0; reported <= '0;
              window_minimum <= kms_pkg::SENTINEL; ring_slot <= '0;
            end
          end else if (accept) begin
            cur_seq <= sequence_index;
            if (sequence_start) begin
              reported <= '0; window_minimum <= kms_pkg::SENTINEL; ring_slot <= '0;
              fcode <= '0; rcode <= '0; base_counter <= '0;
            end
            if (cnt_in != COUNT_MAX) begin
              fcode <= fcode_in; rcode <= rcode_in;
              base_counter <= cnt_in + 1'b1;
              if (cnt_in + 1'b1 >= kms_pkg::pos_t'(k_eff)) begin
                hstart <= 1'b1;
                state <= S_HF;
              end
            end
          end
        end
        S_HF: if (hdone) begin
          fhash <= hout;
          hstart <= 1'b1;
          state <= S_HR;
        end
        S_HR: if (hdone) state <= S_WR;
        S_WR: begin
          // store the new pair and advance the ring
          fring[ring_slot] <= fhash;
          rring[ring_slot] <= hout;
          pring[ring_slot] <= base_counter - kms_pkg::pos_t'(k_eff);
          reported[ring_slot] <= 1'b0;
          ring_slot <= (32'(ring_slot) + 1 >= 32'(w_eff)) ? '0 : ring_slot + 1'b1;
          scan_n <= (kmers < kms_pkg::pos_t'(w_eff)) ? WB'(kmers) : w_eff;
          scan_i <= '0;
          window_minimum <= kms_pkg::SENTINEL;
          state <= S_MIN;
        end
        S_MIN: begin
          if (slot_min < window_minimum) window_minimum <= slot_min;
          if (scan_i + 1'b1 == scan_n) begin
            scan_i <= '0;
            found <= 1'b0;
            state <= (kmers >= kms_pkg::pos_t'(w_eff)) ? S_REP : S_IDLE;
          end else scan_i <= scan_i + 1'b1;
        end
        S_REP: begin
          if (!out_valid || !out_stall) begin
            // a pending result is flushed once the next hit or the end is known
            if (hit) begin
              if (found) begin
                out_valid <= 1'b1;
                last_of_run <= 1'b0;
                kmer_position <= pring[last_s];
                strand <= rring[last_s] < fring[last_s];
                minimizer_hash <= window_minimum[HB-1:0];
                source_sequence <= cur_seq;
              end
              reported[scan_s] <= 1'b1;
              found <= 1'b1;
              last_s <= scan_s;
            end
            if (scan_i + 1'b1 == w_eff) begin
              state <= S_LAST;
            end else scan_i <= scan_i + 1'b1;
          end
        end
        S_LAST: begin
          if (!out_valid || !out_stall) begin
            if (found) begin
              out_valid <= 1'b1;
              last_of_run <= 1'b1;
              kmer_position <= pring[last_s];
              strand <= rring[last_s] < fring[last_s];
              minimizer_hash <= window_minimum[HB-1:0];
              source_sequence <= cur_seq;
            end
            found <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    scan_s = (wrap_sum >= (SB+1)'(w_eff)) ? SB'(wrap_sum - (SB+1)'(w_eff)) : SB'(wrap_sum);
    if (state == S_MIN) scan_s = SB'(scan_i);
  end

  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_rep_min: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> {1'b0, minimizer_hash} == window_minimum) else $error("bad min");
endmodule

@@ rtl/kms_hash_unit.sv @@
// kms_hash_unit: iterative invertible integer hash, one mix step per cycle.
// Depends on kms_pkg.
module kms_hash_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  kms_pkg::hash_t din,
  input  kms_pkg::hash_t mask,
  output logic           done,
  output kms_pkg::hash_t dout
);
  logic [31:0] x;
  logic [31:0] m32;
  logic [31:0] step_val;
  logic [2:0]  step;
  logic        busy;

  assign m32 = 32'(mask);

  // one of the seven mix steps on the working word
  always_comb begin
    case (step)
      3'd0: step_val = (~x + (x << 21)) & m32;
      3'd1: step_val = x ^ (x >> 24);
      3'd2: step_val = (x + (x << 3) + (x << 8)) & m32;
      3'd3: step_val = x ^ (x >> 14);
      3'd4: step_val = (x + (x << 2) + (x << 4)) & m32;
      3'd5: step_val = x ^ (x >> 28);
      3'd6: step_val = (x + (x << 31)) & m32;
      default: step_val = x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 3'd1;
        if (step == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) x <= 32'(din);
    else if (busy) x <= step_val;
  end

  assign dout = x[kms_pkg::HASH_BITS-1:0];
endmodule
